@@ hdl/hrhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types and codes of the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int BodyCountBitsDef = 32;

  localparam int TdataOutBits = 88;

  // byte_kind codes
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_HDR_END = 2'd1;
  localparam logic [1:0] KIND_BODY    = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_SUCCESS    = 2'd0;
  localparam logic [1:0] OUT_MALFORMED  = 2'd1;
  localparam logic [1:0] OUT_INCOMPLETE = 2'd2;
  localparam logic [1:0] OUT_NONE       = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hrhp_in_t;

  typedef struct packed {
    logic [1:0]         byte_kind;
    logic [7:0]         body_data;
    logic               finished;
    logic [1:0]         outcome;
    logic [9:0]         status_code;
    logic signed [31:0] clen;
    logic [31:0]        body_length;
  } hrhp_result_t;

endpackage

@@ hdl/http_response_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-wise HTTP/1.x response parser: status code, content-length, body count.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                  tuser      tlast
// s_axis    in   [7:0] data_byte                        -          last_byte
// m_axis    out  [7:0] body_data, [9:8] outcome,        byte_kind  finished
//                [19:10] status_code, [51:20] clen,
//                [83:52] body_length, [87:84] zero
//
// One byte per clock while m_axis is ready; each beat passes the input register, then the result register.
// The parse stage sits between the input register and the result register.
// Reset returns to the start of a response; so does every beat with tlast.
// A stalled m_axis holds its beat; s_axis keeps accepting until both the
// result register and the input register are full.
// ----------------------------------------------------------------------------
module http_response_header_parser #(
  parameter int BODY_COUNT_BITS = hrhp_pkg::BodyCountBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // data_byte
  input  logic                                s_axis_tlast,  // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // body_data, outcome, status_code, clen, body_length, pad
  output logic [hrhp_pkg::TdataOutBits-1:0]   m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // byte_kind
  output logic                                m_axis_tlast   // finished
);
  import hrhp_pkg::*;

  hrhp_in_t     s_beat;
  hrhp_in_t     in_beat;
  logic         in_valid;
  logic         adv;
  logic         load_ready;
  hrhp_result_t result;
  hrhp_result_t out_result;

  assign s_beat.data_byte = s_axis_tdata;
  assign s_beat.last_byte = s_axis_tlast;

  assign adv = in_valid && load_ready;

  hrhp_in_stage u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_beat_i (s_beat),
    .valid_o  (in_valid),
    .take_i   (adv),
    .beat_o   (in_beat)
  );

  hrhp_parse #(
    .BODY_COUNT_BITS(BODY_COUNT_BITS)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .beat_i  (in_beat),
    .result_o(result)
  );

  hrhp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(in_valid),
    .load_ready_o(load_ready),
    .result_i    (result),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = {4'd0,
                         out_result.body_length,
                         out_result.clen,
                         out_result.status_code,
                         out_result.outcome,
                         out_result.body_data};
  assign m_axis_tuser = out_result.byte_kind;
  assign m_axis_tlast = out_result.finished;

endmodule

@@ hdl/hrhp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_in_stage
// Input register: holds one beat until the parse stage takes it.
// ----------------------------------------------------------------------------
module hrhp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  hrhp_pkg::hrhp_in_t s_beat_i,
  output logic              valid_o,
  input  logic              take_i,
  output hrhp_pkg::hrhp_in_t beat_o
);
  import hrhp_pkg::*;

  logic     valid_q, valid_d;
  hrhp_in_t beat_q;

  // Free slot, or the held beat leaves this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

@@ hdl/hrhp_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_parse
// Parser state and per-byte next-state logic; one byte per advance.
// ----------------------------------------------------------------------------
module hrhp_parse #(
  parameter int BODY_COUNT_BITS = hrhp_pkg::BodyCountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  hrhp_pkg::hrhp_in_t     beat_i,
  output hrhp_pkg::hrhp_result_t result_o
);
  import hrhp_pkg::*;

  localparam logic [2:0] PH_VERSION  = 3'd0;
  localparam logic [2:0] PH_SPACE    = 3'd1;
  localparam logic [2:0] PH_DIGITS   = 3'd2;
  localparam logic [2:0] PH_STATUS   = 3'd3;
  localparam logic [2:0] PH_HEADER   = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;
  localparam logic [2:0] PH_BLANK_CR = 3'd6;
  localparam logic [2:0] PH_BODY     = 3'd7;

  localparam logic [1:0] VM_SPACES = 2'd0;
  localparam logic [1:0] VM_DIGITS = 2'd1;
  localparam logic [1:0] VM_DONE   = 2'd2;

  localparam logic [4:0]  KeyLen    = 5'd15;
  localparam logic [4:0]  LineSat   = 5'd16;
  localparam logic [2:0]  VerLen    = 3'd7;
  localparam logic [34:0] ValMax    = 35'h0_7FFF_FFFF;
  localparam logic [7:0]  ChCr      = 8'h0D;
  localparam logic [7:0]  ChLf      = 8'h0A;
  localparam logic [7:0]  ChSpace   = 8'h20;

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      3'd5:    c = "1";
      default: c = ".";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = ":";
    endcase
    return c;
  endfunction

  logic [2:0]                 phase_q, phase_d;
  logic [2:0]                 ver_idx_q, ver_idx_d;
  logic [9:0]                 status_q, status_d;
  logic [1:0]                 dig_cnt_q, dig_cnt_d;
  logic                       after_cr_q, after_cr_d;
  logic [4:0]                 line_len_q, line_len_d;
  logic                       prefix_q, prefix_d;
  logic [1:0]                 vmode_q, vmode_d;
  logic [30:0]                val_q, val_d;
  logic [31:0]                len_seen_q, len_seen_d;
  logic [BODY_COUNT_BITS-1:0] body_cnt_q, body_cnt_d;
  logic                       err_q, err_d;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic        is_dig;
  logic [3:0]  dig;
  logic [34:0] val_prod;
  logic [30:0] val_acc;
  logic [13:0] st_sum;
  logic [1:0]  kind;
  logic [1:0]  outcome;
  logic [63:0] cnt_ext;

  assign b        = beat_i.data_byte;
  assign lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  assign is_dig   = (b >= "0") && (b <= "9");
  assign dig      = 4'(b - "0");
  assign val_prod = ({4'd0, val_q} << 3) + ({4'd0, val_q} << 1) + {31'd0, dig};
  assign val_acc  = (val_prod > ValMax) ? ValMax[30:0] : val_prod[30:0];
  assign st_sum   = ({4'd0, status_q} << 3) + ({4'd0, status_q} << 1) + {10'd0, dig};

  always_comb begin
    phase_d    = phase_q;
    ver_idx_d  = ver_idx_q;
    status_d   = status_q;
    dig_cnt_d  = dig_cnt_q;
    after_cr_d = after_cr_q;
    line_len_d = line_len_q;
    prefix_d   = prefix_q;
    vmode_d    = vmode_q;
    val_d      = val_q;
    len_seen_d = len_seen_q;
    body_cnt_d = body_cnt_q;
    err_d      = err_q;
    kind       = KIND_HEADER;

    if (err_q) begin
      kind = KIND_DISCARD;
    end else begin
      case (phase_q)
        PH_VERSION: begin
          if ((ver_idx_q < VerLen) ? (b == ver_char(ver_idx_q))
                                   : (b == "0" || b == "1")) begin
            if (ver_idx_q >= VerLen) begin
              phase_d = PH_SPACE;
            end else begin
              ver_idx_d = ver_idx_q + 3'd1;
            end
          end else begin
            err_d = 1'b1;
            kind  = KIND_DISCARD;
          end
        end
        PH_SPACE: begin
          if (b == ChSpace) begin
            phase_d = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            status_d  = st_sum[9:0];
            dig_cnt_d = dig_cnt_q + 2'd1;
            if (dig_cnt_q == 2'd2) begin
              phase_d    = PH_STATUS;
              after_cr_d = 1'b0;
            end
          end else begin
            err_d = 1'b1;
            kind  = KIND_DISCARD;
          end
        end
        PH_STATUS: begin
          if (b == ChLf && after_cr_q) begin
            phase_d    = PH_HEADER;
            line_len_d = '0;
            prefix_d   = 1'b1;
            vmode_d    = VM_SPACES;
            val_d      = '0;
          end
          after_cr_d = (b == ChCr);
        end
        PH_HEADER: begin
          if (b == ChCr) begin
            if (line_len_q == '0) begin
              phase_d = PH_BLANK_CR;
            end else begin
              if (prefix_q && line_len_q >= LineSat) begin
                len_seen_d = {1'b0, val_q};
              end
              phase_d = PH_SKIP;
            end
          end else begin
            if (line_len_q < KeyLen) begin
              if (lc != key_char(line_len_q[3:0])) begin
                prefix_d = 1'b0;
              end
            end else if (vmode_q == VM_SPACES) begin
              if (is_dig) begin
                vmode_d = VM_DIGITS;
                val_d   = val_acc;
              end else if (b != ChSpace) begin
                vmode_d = VM_DONE;
              end
            end else if (vmode_q == VM_DIGITS) begin
              if (is_dig) begin
                val_d = val_acc;
              end else begin
                vmode_d = VM_DONE;
              end
            end
            if (line_len_q < LineSat) begin
              line_len_d = line_len_q + 5'd1;
            end
          end
        end
        PH_SKIP: begin
          phase_d    = PH_HEADER;
          line_len_d = '0;
          prefix_d   = 1'b1;
          vmode_d    = VM_SPACES;
          val_d      = '0;
        end
        PH_BLANK_CR: begin
          if (b == ChLf) begin
            phase_d = PH_BODY;
            kind    = KIND_HDR_END;
          end else begin
            phase_d    = PH_HEADER;
            line_len_d = '0;
            prefix_d   = 1'b1;
            vmode_d    = VM_SPACES;
            val_d      = '0;
          end
        end
        default: begin
          kind = KIND_BODY;
          if (!(&body_cnt_q)) begin
            body_cnt_d = body_cnt_q + 1'b1;
          end
        end
      endcase
    end

    // A stream ending on a line boundary, or one byte into a new line, is complete.
    if (!beat_i.last_byte) begin
      outcome = OUT_SUCCESS;
    end else if (err_d) begin
      outcome = OUT_MALFORMED;
    end else if (phase_d == PH_VERSION) begin
      outcome = OUT_NONE;
    end else if (phase_d == PH_BODY || phase_d == PH_BLANK_CR ||
                 (phase_d == PH_HEADER && line_len_d <= 5'd1)) begin
      outcome = OUT_SUCCESS;
    end else begin
      outcome = OUT_INCOMPLETE;
    end
  end

  assign cnt_ext = 64'(body_cnt_d);

  always_comb begin
    result_o.byte_kind   = kind;
    result_o.body_data   = (kind == KIND_BODY) ? b : 8'd0;
    result_o.finished    = beat_i.last_byte;
    result_o.outcome     = outcome;
    result_o.status_code = (dig_cnt_d == 2'd3) ? status_d : 10'd0;
    result_o.clen        = len_seen_d;
    result_o.body_length = (|cnt_ext[63:32]) ? 32'hFFFF_FFFF : cnt_ext[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VERSION;
      ver_idx_q  <= '0;
      status_q   <= '0;
      dig_cnt_q  <= '0;
      after_cr_q <= 1'b0;
      line_len_q <= '0;
      prefix_q   <= 1'b1;
      vmode_q    <= VM_SPACES;
      val_q      <= '0;
      len_seen_q <= '1;
      body_cnt_q <= '0;
      err_q      <= 1'b0;
    end else if (adv_i && beat_i.last_byte) begin
      // last beat: back to the idle state for the next response
      phase_q    <= PH_VERSION;
      ver_idx_q  <= '0;
      status_q   <= '0;
      dig_cnt_q  <= '0;
      after_cr_q <= 1'b0;
      line_len_q <= '0;
      prefix_q   <= 1'b1;
      vmode_q    <= VM_SPACES;
      val_q      <= '0;
      len_seen_q <= '1;
      body_cnt_q <= '0;
      err_q      <= 1'b0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      ver_idx_q  <= ver_idx_d;
      status_q   <= status_d;
      dig_cnt_q  <= dig_cnt_d;
      after_cr_q <= after_cr_d;
      line_len_q <= line_len_d;
      prefix_q   <= prefix_d;
      vmode_q    <= vmode_d;
      val_q      <= val_d;
      len_seen_q <= len_seen_d;
      body_cnt_q <= body_cnt_d;
      err_q      <= err_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && beat_i.last_byte |=> phase_q == PH_VERSION && !err_q && len_seen_q == '1)
    else $error("parser did not restart after last beat");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && err_q && !beat_i.last_byte |=> err_q)
    else $error("error flag dropped inside a response");

  a_body_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY || phase_q == PH_HEADER |-> dig_cnt_q == 2'd3)
    else $error("header or body phase without a full status code");

  a_body_count_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_BODY |-> body_cnt_q == '0)
    else $error("body count moved outside the body");

endmodule

@@ hdl/hrhp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_out_stage
// Result register with valid flag; loads while the held beat drains.
// ----------------------------------------------------------------------------
module hrhp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_valid_i,
  output logic                   load_ready_o,
  input  hrhp_pkg::hrhp_result_t result_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output hrhp_pkg::hrhp_result_t result_o
);
  import hrhp_pkg::*;

  logic         valid_q, valid_d;
  hrhp_result_t result_q;

  assign load_ready_o = !valid_q || m_ready_i;
  assign valid_d      = load_ready_o ? load_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams HTTP/1.x responses, whole, truncated, corrupted and pure noise,
// through http_response_header_parser with random gaps on both sides. Each
// result beat is checked field by field against the model or a typed row.
// ----------------------------------------------------------------------------
module testbench;
  import hrhp_pkg::*;

  localparam int BodyCountBits = 32;
  localparam longint unsigned BodyMax = (64'd1 << BodyCountBits) - 1;
  localparam int unsigned ValueMax = 32'h7FFF_FFFF;
  localparam int CycleLimit = 400000;
  localparam int unsigned RandomBytes = 750;
  localparam string VersionText = "HTTP/1.";
  localparam string KeyText = "content-length:";
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;

  typedef enum logic [2:0] {
    ST_VERSION, ST_SPACE, ST_CODE, ST_STATUS_LINE, ST_HEADER, ST_SKIP, ST_BLANK_CR, ST_BODY
  } parse_st_e;

  typedef enum logic [1:0] {VAL_SPACES, VAL_DIGITS, VAL_DONE} value_st_e;

  // one input beat; typed rows carry their result spelled out
  typedef struct packed {
    logic [7:0]   b;
    logic         last;
    logic         typed;
    hrhp_result_t res;
  } beat_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata;   // data_byte
  logic                    s_axis_tlast;   // last_byte
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // body_data, outcome, status_code, clen, body_length, pad
  logic [TdataOutBits-1:0] m_axis_tdata;
  logic [1:0]              m_axis_tuser;   // byte_kind
  logic                    m_axis_tlast;   // finished

  beat_t        byte_stream[$];
  hrhp_result_t pending_results[$];
  hrhp_result_t head_result;
  int           n_fail = 0;
  int           n_cycles = 0;

  // parser model state
  parse_st_e       p_state;
  int unsigned     p_ver_idx;
  int unsigned     p_code;
  int unsigned     p_ndigits;
  logic            p_after_cr;
  int unsigned     p_line_len;
  logic            p_key_ok;
  value_st_e       p_vmode;
  int unsigned     p_value;
  logic [31:0]     p_clen;
  longint unsigned p_body;
  logic            p_err;

  http_response_header_parser #(
    .BODY_COUNT_BITS(BodyCountBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic is_dec(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int unsigned add_digit(int unsigned acc, int unsigned d);
    if (acc > (ValueMax - d) / 10) return ValueMax;
    return acc * 10 + d;
  endfunction

  function automatic void start_line();
    p_line_len = 0;
    p_key_ok = 1'b1;
    p_vmode = VAL_SPACES;
    p_value = 0;
  endfunction

  function automatic void reset_parser();
    p_state = ST_VERSION;
    p_ver_idx = 0;
    p_code = 0;
    p_ndigits = 0;
    p_after_cr = 1'b0;
    start_line();
    p_clen = '1;
    p_body = 0;
    p_err = 1'b0;
  endfunction

  function automatic hrhp_result_t parse_byte(logic [7:0] b, logic last);
    hrhp_result_t r;
    logic [1:0] kind;
    logic [1:0] fate;
    logic [7:0] lc;
    kind = KIND_HEADER;
    fate = OUT_SUCCESS;
    if (p_err) begin
      kind = KIND_DISCARD;
    end else begin
      case (p_state)
        ST_VERSION: begin
          if (p_ver_idx < 7 ? b == VersionText[p_ver_idx] : (b == "0" || b == "1")) begin
            if (p_ver_idx >= 7) p_state = ST_SPACE;
            else p_ver_idx++;
          end else begin
            p_err = 1'b1;
            kind = KIND_DISCARD;
          end
        end
        ST_SPACE: if (b == " ") p_state = ST_CODE;
        ST_CODE: begin
          if (is_dec(b)) begin
            p_code = p_code * 10 + (b - "0");
            p_ndigits++;
            if (p_ndigits >= 3) begin
              p_state = ST_STATUS_LINE;
              p_after_cr = 1'b0;
            end
          end else begin
            p_err = 1'b1;
            kind = KIND_DISCARD;
          end
        end
        ST_STATUS_LINE: begin
          if (b == LF && p_after_cr) begin
            p_state = ST_HEADER;
            start_line();
          end
          p_after_cr = (b == CR);
        end
        ST_HEADER: begin
          if (b == CR) begin
            if (p_line_len == 0) begin
              p_state = ST_BLANK_CR;
            end else begin
              // value only counts once the key plus one more byte was seen
              if (p_key_ok && p_line_len >= 16) p_clen = p_value;
              p_state = ST_SKIP;
            end
          end else begin
            if (p_line_len < 15) begin
              lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
              if (lc != KeyText[p_line_len]) p_key_ok = 1'b0;
            end else if (p_vmode == VAL_SPACES) begin
              if (is_dec(b)) begin
                p_vmode = VAL_DIGITS;
                p_value = add_digit(p_value, b - "0");
              end else if (b != " ") begin
                p_vmode = VAL_DONE;
              end
            end else if (p_vmode == VAL_DIGITS) begin
              if (is_dec(b)) p_value = add_digit(p_value, b - "0");
              else p_vmode = VAL_DONE;
            end
            if (p_line_len < 16) p_line_len++;
          end
        end
        ST_SKIP: begin
          p_state = ST_HEADER;
          start_line();
        end
        ST_BLANK_CR: begin
          if (b == LF) begin
            p_state = ST_BODY;
            kind = KIND_HDR_END;
          end else begin
            p_state = ST_HEADER;
            start_line();
          end
        end
        default: begin
          kind = KIND_BODY;
          if (p_body < BodyMax) p_body++;
        end
      endcase
    end

    if (last) begin
      if (p_err) fate = OUT_MALFORMED;
      else if (p_state == ST_VERSION) fate = OUT_NONE;
      else if (p_state == ST_BODY || p_state == ST_BLANK_CR ||
               (p_state == ST_HEADER && p_line_len <= 1)) fate = OUT_SUCCESS;
      else fate = OUT_INCOMPLETE;
    end

    r.byte_kind = kind;
    r.body_data = (kind == KIND_BODY) ? b : 8'd0;
    r.finished = last;
    r.outcome = fate;
    r.status_code = (p_ndigits >= 3) ? p_code[9:0] : 10'd0;
    r.clen = p_clen;
    r.body_length = (p_body > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p_body[31:0];
    if (last) reset_parser();
    return r;
  endfunction

  function automatic beat_t plain(logic [7:0] b, logic last);
    beat_t r;
    r = '0;
    r.b = b;
    r.last = last;
    return r;
  endfunction

  // closing byte whose whole result is known by inspection
  function automatic beat_t typed_end(logic [7:0] b, logic [1:0] kind, logic [1:0] fate);
    beat_t r;
    r = plain(b, 1'b1);
    r.typed = 1'b1;
    r.res.byte_kind = kind;
    r.res.finished = 1'b1;
    r.res.outcome = fate;
    r.res.clen = -1;
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic put_text(ref logic [7:0] s[$], input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endtask

  task automatic add_header(ref logic [7:0] s[$]);
    int pick;
    logic [7:0] c;
    pick = $urandom_range(9);
    if (pick < 5) begin
      for (int i = 0; i < KeyText.len(); i++) begin
        c = KeyText[i];
        s.push_back((c >= "a" && c <= "z" && $urandom_range(1) == 1) ? c - 8'd32 : c);
      end
      repeat ($urandom_range(0, 2)) s.push_back(" ");
      // long digit runs push the value into saturation
      repeat ($urandom_range(3) == 0 ? $urandom_range(8, 13) : $urandom_range(0, 4))
        s.push_back(8'("0" + $urandom_range(9)));
      if ($urandom_range(3) == 0) s.push_back(rand_letter());
    end else if (pick < 7) begin
      if (pick == 5) put_text(s, "content-type: ");
      else put_text(s, "x-");
      repeat ($urandom_range(1, 6)) s.push_back(rand_letter());
    end else if (pick == 7) begin
      // empty line whose CR is not followed by LF
      s.push_back(CR);
      s.push_back(rand_letter());
      return;
    end else begin
      repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(255)));
    end
    s.push_back(CR);
    s.push_back($urandom_range(7) == 0 ? rand_letter() : LF);
  endtask

  task automatic gen_response(ref int unsigned n_bytes);
    logic [7:0] s[$];
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(255)));
    end else begin
      put_text(s, VersionText);
      s.push_back($urandom_range(1) == 1 ? "1" : "0");
      if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) s.push_back(rand_letter());
      s.push_back(" ");
      repeat (3) s.push_back(8'("0" + $urandom_range(9)));
      repeat ($urandom_range(0, 4)) begin
        n = $urandom_range(9);
        s.push_back(n == 0 ? CR : n == 1 ? LF : n == 2 ? 8'h20 : rand_letter());
      end
      s.push_back(CR);
      s.push_back(LF);
      repeat ($urandom_range(0, 2)) add_header(s);
      s.push_back(CR);
      s.push_back(LF);
      repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(255)));
      if (pick < 20) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
      else if (pick < 55) s = s[0:$urandom_range(s.size() - 1)];
    end
    foreach (s[i]) byte_stream.push_back(plain(s[i], i == s.size() - 1));
    n_bytes += s.size();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  initial begin
    beat_t        dir_rows [23];
    beat_t        cur;
    hrhp_result_t res;
    int unsigned  n_rand;
    int           gap;
    int           calm;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tlast = 1'b0;

    dir_rows = '{
      typed_end("X", KIND_DISCARD, OUT_MALFORMED),
      typed_end("H", KIND_HEADER, OUT_NONE),
      typed_end(8'hFF, KIND_DISCARD, OUT_MALFORMED),
      typed_end(8'h00, KIND_DISCARD, OUT_MALFORMED),
      plain("H", 1'b0), plain("T", 1'b0), plain("T", 1'b0), plain("P", 1'b0),
      plain("/", 1'b0), plain("1", 1'b0), plain(".", 1'b0), plain("1", 1'b0),
      plain(" ", 1'b0), plain("2", 1'b0),
      typed_end("Z", KIND_DISCARD, OUT_MALFORMED),
      plain("H", 1'b0), plain("T", 1'b0), plain("T", 1'b0), plain("P", 1'b0),
      plain("/", 1'b0), plain("1", 1'b0), plain(".", 1'b0),
      typed_end("0", KIND_HEADER, OUT_INCOMPLETE)
    };
    foreach (dir_rows[i]) byte_stream.push_back(dir_rows[i]);
    n_rand = 0;
    while (n_rand < RandomBytes) gen_response(n_rand);

    reset_parser();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    calm = 0;
    foreach (byte_stream[i]) begin
      cur = byte_stream[i];
      gap = 0;
      if (calm > 0) calm--;
      else if ($urandom_range(24) == 0) calm = $urandom_range(20, 80);
      else gap = idle_len();
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata = cur.b;
      s_axis_tlast = cur.last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      res = parse_byte(cur.b, cur.last);
      pending_results.push_back(cur.typed ? cur.res : res);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) $display("http_response_header_parser regression: pass");
    else $display("http_response_header_parser regression: fail");
    $finish;
  end

  // result side backpressure
  initial begin
    int g;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      g = idle_len();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(9) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 6))
        @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual tdata %h", $time,
                 m_axis_tdata);
        n_fail++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("byte_kind", 32'(head_result.byte_kind), 32'(m_axis_tuser));
        check_field("body_data", 32'(head_result.body_data), 32'(m_axis_tdata[7:0]));
        check_field("finished", 32'(head_result.finished), 32'(m_axis_tlast));
        check_field("outcome", 32'(head_result.outcome), 32'(m_axis_tdata[9:8]));
        check_field("status_code", 32'(head_result.status_code), 32'(m_axis_tdata[19:10]));
        check_field("clen", head_result.clen, m_axis_tdata[51:20]);
        check_field("body_length", head_result.body_length, m_axis_tdata[83:52]);
        check_field("pad", 32'd0, 32'(m_axis_tdata[87:84]));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("http_response_header_parser regression: fail");
      $finish;
    end
  end

endmodule
